/* hw/rtl/four_level_page_table_walker_assert.svh */
// Assertion macros used by the walker's top-level RTL file.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// Same-cycle implication, inactive while reset is high.
`define PGW_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is high.
`define PGW_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pgw_pkg.sv */
package pgw_pkg;

  localparam int unsigned TABLE_WORDS_DEF = 4096;

  localparam int unsigned PA_W    = 52;
  localparam int unsigned VA_W    = 48;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned LVL_W   = 9;
  localparam int unsigned WADDR_W = 49;

  localparam logic REQ_WRITE     = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  localparam int unsigned PTE_PRESENT   = 0;
  localparam int unsigned PTE_PAGE_SIZE = 7;

  localparam logic [ST_W-1:0] ST_PAGE_4K  = 3'd0;
  localparam logic [ST_W-1:0] ST_PAGE_2M  = 3'd1;
  localparam logic [ST_W-1:0] ST_PAGE_1G  = 3'd2;
  localparam logic [ST_W-1:0] ST_UNMAPPED = 3'd3;
  localparam logic [ST_W-1:0] ST_OUTSIDE  = 3'd4;
  localparam logic [ST_W-1:0] ST_WRITTEN  = 3'd5;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  word_index;
    logic [DATA_W-1:0] word_data;
    logic [VA_W-1:0]   virt_addr;
  } pgw_in_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    logic [ST_W-1:0] status;
  } pgw_out_t;

endpackage

/* hw/rtl/pgw_table_mem.sv */
module pgw_table_mem #(
  parameter int unsigned TABLE_WORDS = pgw_pkg::TABLE_WORDS_DEF,
  parameter int unsigned AW          = $clog2(TABLE_WORDS)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [pgw_pkg::DATA_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [pgw_pkg::DATA_W-1:0]  rd_data
);
  import pgw_pkg::*;

  logic [DATA_W-1:0] mem [TABLE_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/pgw_walk_ctrl.sv */
module pgw_walk_ctrl #(
  parameter int unsigned TABLE_WORDS = pgw_pkg::TABLE_WORDS_DEF,
  parameter int unsigned AW          = $clog2(TABLE_WORDS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [pgw_pkg::PA_W-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pgw_pkg::pgw_in_t            in_req,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [pgw_pkg::DATA_W-1:0]  mem_wr_data,
  output logic                        mem_rd_en,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [pgw_pkg::DATA_W-1:0]  mem_rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output pgw_pkg::pgw_out_t           res
);
  import pgw_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  localparam logic [DATA_W-1:0] WORDS_EXT = DATA_W'(TABLE_WORDS);
  localparam logic [AW-1:0]     LAST_WORD = AW'(TABLE_WORDS - 1);

  logic [1:0]        state, state_next;
  logic [1:0]        level, level_next;
  logic [VA_W-1:0]   va;
  logic [PA_W-1:0]   root;
  logic [AW-1:0]     clr_addr;
  logic [PA_W-1:0]   res_pa, res_pa_next;
  logic [ST_W-1:0]   res_st, res_st_next;

  logic              accept;
  logic [LVL_W-1:0]  next_idx;
  logic [WADDR_W-1:0] root_word, walk_word;
  logic              root_in, walk_in, write_in;
  logic [DATA_W-1:0] wr_idx_ext;
  logic              present, large_page;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{phys_addr: res_pa, status: res_st};

  assign present    = mem_rd_data[PTE_PRESENT];
  assign large_page = mem_rd_data[PTE_PAGE_SIZE];

  always_comb begin
    case (level)
      LVL_PML4: next_idx = va[38:30];
      LVL_PDPT: next_idx = va[29:21];
      LVL_PD:   next_idx = va[20:12];
      default:  next_idx = va[20:12];
    endcase
  end

  assign root_word  = {root[PA_W-1:12], in_req.virt_addr[47:39]};
  assign walk_word  = {mem_rd_data[PA_W-1:12], next_idx};
  assign root_in    = (DATA_W'(root_word) < WORDS_EXT);
  assign walk_in    = (DATA_W'(walk_word) < WORDS_EXT);
  assign wr_idx_ext = DATA_W'(in_req.word_index);
  assign write_in   = (wr_idx_ext < WORDS_EXT);

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = '0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = walk_word[AW-1:0];
    state_next  = state;
    level_next  = level;
    res_pa_next = res_pa;
    res_st_next = res_st;
    case (state)
      S_CLEAR: begin
        mem_wr_en = 1'b1;
        if (clr_addr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_rd_addr = root_word[AW-1:0];
        if (accept) begin
          res_pa_next = '0;
          if (in_req.req_type == REQ_WRITE) begin
            mem_wr_en   = write_in;
            mem_wr_addr = wr_idx_ext[AW-1:0];
            mem_wr_data = in_req.word_data;
            res_st_next = ST_WRITTEN;
            state_next  = S_DONE;
          end else if (!root_in) begin
            res_st_next = ST_OUTSIDE;
            state_next  = S_DONE;
          end else begin
            mem_rd_en  = 1'b1;
            level_next = LVL_PML4;
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        state_next = S_DONE;
        if (!present) begin
          res_st_next = ST_UNMAPPED;
        end else if (level == LVL_PT) begin
          res_pa_next = {mem_rd_data[PA_W-1:12], va[11:0]};
          res_st_next = ST_PAGE_4K;
        end else if (level == LVL_PDPT && large_page) begin
          res_pa_next = {mem_rd_data[PA_W-1:30], va[29:0]};
          res_st_next = ST_PAGE_1G;
        end else if (level == LVL_PD && large_page) begin
          res_pa_next = {mem_rd_data[PA_W-1:21], va[20:0]};
          res_st_next = ST_PAGE_2M;
        end else if (!walk_in) begin
          res_st_next = ST_OUTSIDE;
        end else begin
          mem_rd_en  = 1'b1;
          level_next = level + 2'd1;
          state_next = S_WALK;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      root     <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_write) begin
        root <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    level  <= level_next;
    res_pa <= res_pa_next;
    res_st <= res_st_next;
    if (accept) begin
      va <= in_req.virt_addr;
    end
  end

endmodule

/* hw/rtl/four_level_page_table_walker.sv */
// Four-level x86-64 page table walker with its own table memory of TABLE_WORDS 64-bit words,
// word w holding physical byte address 8*w. A write request stores one word, if its index lies
// inside the memory, and answers with status 5; a translate request walks PML4, PDPT, PD and PT
// from the root register and answers with the physical address and a status (4K, 2M or 1G page,
// not mapped, or table outside the memory). Requests are handled one at a time; a translation
// makes up to four table reads, since each level waits for the registered read of the single
// table memory before the next address is known. After reset the memory is cleared one word a
// cycle, and no request is taken until every word is cleared; root register writes are taken
// throughout. A finished result sits in an output register, so the next request is taken while
// it waits to be collected.
`include "four_level_page_table_walker_assert.svh"

module four_level_page_table_walker #(
  parameter int unsigned TABLE_WORDS = pgw_pkg::TABLE_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [pgw_pkg::PA_W-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  pgw_pkg::pgw_in_t          in_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pgw_pkg::pgw_out_t         out_resp
);
  import pgw_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_WORDS);

  logic              mem_wr_en, mem_rd_en;
  logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
  logic [DATA_W-1:0] mem_wr_data, mem_rd_data;
  logic              res_valid, res_ready;
  pgw_out_t          res;

  pgw_walk_ctrl #(
    .TABLE_WORDS(TABLE_WORDS),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .mem_wr_en(mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en(mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  pgw_table_mem #(
    .TABLE_WORDS(TABLE_WORDS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .wr_en(mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en(mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_resp <= res;
    end
  end

  `PGW_ASSERT_NEXT(a_write_answers, clk, rst,
    in_valid && !in_stall && in_req.req_type == REQ_WRITE,
    res_valid && res.status == ST_WRITTEN,
    "write request did not produce a write-done result")

  `PGW_ASSERT_SAME(a_fail_zero_addr, clk, rst,
    res_valid && (res.status == ST_UNMAPPED || res.status == ST_OUTSIDE ||
      res.status == ST_WRITTEN),
    res.phys_addr == '0,
    "non-translation result carries a non-zero address")

  `PGW_ASSERT_SAME(a_no_accept_pending, clk, rst,
    !in_stall,
    !res_valid,
    "request could be taken while a result is still pending")

endmodule
